// File: sv/tee_pkg.sv
// Shared types, codes and helpers of the translation embedding update block.
`default_nettype none
package tee_pkg;

  localparam int ELEMENT_BITS = 16;
  localparam int FRAC_BITS    = 14;

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;

  localparam logic [2:0] OPC_WR_ENT = 3'd0;
  localparam logic [2:0] OPC_WR_REL = 3'd1;
  localparam logic [2:0] OPC_RD_ENT = 3'd2;
  localparam logic [2:0] OPC_RD_REL = 3'd3;
  localparam logic [2:0] OPC_TRAIN  = 3'd4;

  localparam logic [1:0] KIND_POS  = 2'd0;
  localparam logic [1:0] KIND_NEAR = 2'd1;
  localparam logic [1:0] KIND_FAR  = 2'd2;

  localparam logic [2:0] CFG_MEASURE = 3'd0;
  localparam logic [2:0] CFG_DIM     = 3'd1;
  localparam logic [2:0] CFG_STEP    = 3'd2;
  localparam logic [2:0] CFG_PMARGIN = 3'd3;
  localparam logic [2:0] CFG_FMARGIN = 3'd4;

  localparam logic [30:0] DIST_MAX = '1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  head_index;
    logic [9:0]  tail_index;
    logic [5:0]  relation_index;
    logic [1:0]  sample_kind;
    logic [14:0] threshold;
    logic [6:0]  element_index;
    logic signed [15:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [30:0] distance;
    logic        updated;
    logic signed [15:0] read_value;
  } out_item_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_WRITE, DP_RD_ADDR, DP_RD_DATA,
    DP_ADDR_HR, DP_ADDR_T, DP_D_DIFF, DP_SQUARE, DP_PASS, DP_ACC,
    DP_SQRT_START, DP_DIST, DP_MARG_MUL, DP_MARG_CMP,
    DP_UPD_BEGIN, DP_U_WRITE_HR, DP_U_WRITE_T,
    DP_N_BEGIN, DP_N_ADDR, DP_N_MAG, DP_N_LATCH,
    DP_S_DIV, DP_S_WRITE, DP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {ROW_HEAD, ROW_TAIL, ROW_REL} row_sel_t;

  typedef struct packed {
    dp_op_t   op;
    row_sel_t row;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] operation;
    logic       train_ok;
    logic       dim_zero;
    logic       idx_last;
    logic       use_l2;
    logic       sqrt_busy;
    logic       div_busy;
    logic       fire;
    logic       big;
    logic       out_free;
  } dp_status_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE, S_WRITE, S_RD_ADDR, S_RD_DATA,
    S_D_A, S_D_B, S_D_C, S_D_D, S_D_E, S_D_SQRT, S_D_WAIT,
    S_DIST, S_MARG_MUL, S_MARG_CMP, S_CHECK, S_UPD_BEGIN,
    S_U_A, S_U_B, S_U_C, S_U_D,
    S_N_BEGIN, S_N_A, S_N_B, S_N_C, S_N_D, S_N_E, S_N_WAIT, S_N_LATCH,
    S_S_A, S_S_B, S_S_WAIT, S_S_C, S_NEXT_ROW, S_FINISH
  } ctrl_state_t;

  function automatic elem_t sat_el(input logic signed [17:0] v);
    elem_t r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/tee_if.sv
// Item, result and configuration channel interfaces.
`default_nettype none
interface tee_in_if;
  import tee_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tee_out_if;
  import tee_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tee_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/tee_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tee_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/tee_datapath.sv
// Datapath: tables, configuration, distance, step, norm, square root and divide.
`default_nettype none
module tee_datapath #(
  parameter int ENTITY_ROWS   = 1024,
  parameter int RELATION_ROWS = 64,
  parameter int MAX_DIMENSION = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tee_pkg::dp_cmd_t     cmd,
  output      tee_pkg::dp_status_t  status,
  input  wire tee_pkg::in_item_t    in_item,
  input  wire logic                 cfg_valid,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [14:0]          cfg_data,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_ready,
  output      tee_pkg::out_item_t   rsp_item
);
  import tee_pkg::*;

  localparam int E_DEPTH = ENTITY_ROWS * MAX_DIMENSION;
  localparam int R_DEPTH = RELATION_ROWS * MAX_DIMENSION;
  localparam int EA_W    = (E_DEPTH > 1) ? $clog2(E_DEPTH) : 1;
  localparam int RA_W    = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int ACC_W   = 34 + DIM_W;
  localparam int SQ_W    = ACC_W + (ACC_W % 2);
  localparam int ROOT_W  = SQ_W / 2;
  localparam int SQC_W   = $clog2(ROOT_W + 1);
  localparam int DV_W    = ELEMENT_BITS + FRAC_BITS;
  localparam int DVC_W   = $clog2(DV_W + 1);
  localparam logic [EA_W-1:0] E_STRIDE = EA_W'(MAX_DIMENSION);
  localparam logic [RA_W-1:0] R_STRIDE = RA_W'(MAX_DIMENSION);
  localparam logic [ACC_W-1:0] ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);

  // configuration
  logic        meas;
  logic [7:0]  dim;
  logic [10:0] step;
  logic [14:0] pmargin;
  logic [14:0] fmargin;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas    <= 1'b1;
      dim     <= 8'd100;
      step    <= 11'd8;
      pmargin <= 15'd1638;
      fmargin <= 15'd8192;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MEASURE: meas    <= cfg_data[0];
        CFG_DIM:     dim     <= cfg_data[7:0];
        CFG_STEP:    step    <= cfg_data[10:0];
        CFG_PMARGIN: pmargin <= cfg_data;
        CFG_FMARGIN: fmargin <= cfg_data;
        default: ;
      endcase
    end
  end

  // item and working registers
  in_item_t          it;
  logic [DIM_W-1:0]  idx;
  elem_t             hv, rv, tn;
  logic [16:0]       xm;
  logic [33:0]       sq;
  logic [ACC_W-1:0]  acc;
  logic [30:0]       tdist;
  logic [29:0]       prod;
  logic              fire;
  logic              upd;
  elem_t             rd;
  logic [ROOT_W-1:0] nrm;

  logic [DIM_W-1:0] d_eff;
  assign d_eff = (32'(dim) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(dim);

  logic ent_ok_h, ent_ok_t, rel_ok_r, rel_ok_h, ei_ok;
  assign ent_ok_h = 32'(it.head_index) < ENTITY_ROWS;
  assign ent_ok_t = 32'(it.tail_index) < ENTITY_ROWS;
  assign rel_ok_r = 32'(it.relation_index) < RELATION_ROWS;
  assign rel_ok_h = 32'(it.head_index) < RELATION_ROWS;
  assign ei_ok    = 32'(it.element_index) < MAX_DIMENSION;

  logic [EA_W-1:0] h_addr, t_addr, e_item_addr;
  logic [RA_W-1:0] r_addr, r_item_addr;
  assign h_addr      = EA_W'(it.head_index) * E_STRIDE + EA_W'(idx);
  assign t_addr      = EA_W'(it.tail_index) * E_STRIDE + EA_W'(idx);
  assign r_addr      = RA_W'(it.relation_index) * R_STRIDE + RA_W'(idx);
  assign e_item_addr = EA_W'(it.head_index) * E_STRIDE + EA_W'(it.element_index);
  assign r_item_addr = RA_W'(it.head_index) * R_STRIDE + RA_W'(it.element_index);

  // memories
  logic            e_we, r_we;
  logic [EA_W-1:0] e_waddr, e_raddr;
  logic [RA_W-1:0] r_waddr, r_raddr;
  elem_t           e_wdata, r_wdata, e_q, r_q;

  tee_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(E_DEPTH)) u_ent_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_q)
  );

  tee_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(R_DEPTH)) u_rel_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_q)
  );

  // element arithmetic
  logic signed [17:0] te, he, re, xd, s_val, tb;
  elem_t              rn, hn, sel_q, dv_res;
  logic               s_pos;
  logic [16:0]        sel_mag;

  assign te    = 18'(e_q);
  assign he    = 18'(hv);
  assign re    = 18'(rv);
  assign xd    = te - he - re;
  assign s_pos = (xd > 18'sd0) ^ (it.sample_kind == KIND_POS);
  assign s_val = s_pos ? $signed(18'(step)) : -$signed(18'(step));
  assign rn    = sat_el(re - s_val);
  assign hn    = sat_el(he - s_val);
  assign tb    = (it.head_index == it.tail_index) ? 18'(hn) : te;
  assign sel_q = (cmd.row == ROW_REL) ? r_q : e_q;
  assign sel_mag = sel_q[15] ? 17'(-18'(sel_q)) : 17'(sel_q);

  // margin
  logic signed [17:0] base;
  logic signed [32:0] dd;
  assign base = $signed(18'(pmargin)) - $signed(18'(prod[29:14]));
  assign dd   = $signed({2'b00, tdist});

  // square root unit
  logic [SQ_W-1:0]   sq_x;
  logic [ROOT_W:0]   sq_rem;
  logic [ROOT_W-1:0] sq_root;
  logic [SQC_W-1:0]  sq_cnt;
  logic              sq_busy;
  logic [ROOT_W+2:0] sq_rs, sq_trial, sq_diff;
  logic              sq_ge;
  assign sq_rs    = {sq_rem, sq_x[SQ_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = sq_rs >= sq_trial;
  assign sq_diff  = sq_rs - sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.op == DP_SQRT_START) begin
      sq_x    <= SQ_W'(acc);
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= SQC_W'(ROOT_W);
      sq_busy <= 1'b1;
    end else if (sq_busy) begin
      sq_x    <= sq_x << 2;
      sq_rem  <= sq_ge ? sq_diff[ROOT_W:0] : sq_rs[ROOT_W:0];
      sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
      sq_cnt  <= sq_cnt - 1'b1;
      if (sq_cnt == SQC_W'(1)) begin
        sq_busy <= 1'b0;
      end
    end
  end

  // divide unit
  logic [DV_W-1:0]   dv_q;
  logic [ROOT_W-1:0] dv_rem;
  logic [DVC_W-1:0]  dv_cnt;
  logic              dv_busy, dv_neg;
  logic [ROOT_W:0]   dv_rs, dv_diff;
  logic              dv_ge;
  assign dv_rs   = {dv_rem, dv_q[DV_W-1]};
  assign dv_ge   = dv_rs >= {1'b0, nrm};
  assign dv_diff = dv_rs - {1'b0, nrm};
  assign dv_res  = dv_neg ? -dv_q[15:0] : dv_q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.op == DP_S_DIV) begin
      dv_q    <= DV_W'({sel_mag[15:0], 14'b0});
      dv_neg  <= sel_q[15];
      dv_rem  <= '0;
      dv_cnt  <= DVC_W'(DV_W);
      dv_busy <= 1'b1;
    end else if (dv_busy) begin
      dv_q    <= {dv_q[DV_W-2:0], dv_ge};
      dv_rem  <= dv_ge ? dv_diff[ROOT_W-1:0] : dv_rs[ROOT_W-1:0];
      dv_cnt  <= dv_cnt - 1'b1;
      if (dv_cnt == DVC_W'(1)) begin
        dv_busy <= 1'b0;
      end
    end
  end

  // memory ports
  always_comb begin
    e_we    = 1'b0;
    r_we    = 1'b0;
    e_waddr = h_addr;
    r_waddr = r_addr;
    e_wdata = it.element_value;
    r_wdata = it.element_value;
    e_raddr = h_addr;
    r_raddr = r_addr;
    case (cmd.op)
      DP_WRITE: begin
        e_waddr = e_item_addr;
        r_waddr = r_item_addr;
        e_we    = (it.operation == OPC_WR_ENT) && ent_ok_h && ei_ok;
        r_we    = (it.operation == OPC_WR_REL) && rel_ok_h && ei_ok;
      end
      DP_RD_ADDR: begin
        e_raddr = e_item_addr;
        r_raddr = r_item_addr;
      end
      DP_ADDR_T: e_raddr = t_addr;
      DP_N_ADDR: e_raddr = (cmd.row == ROW_TAIL) ? t_addr : h_addr;
      DP_U_WRITE_HR: begin
        e_we    = 1'b1;
        r_we    = 1'b1;
        e_wdata = hn;
        r_wdata = rn;
      end
      DP_U_WRITE_T: begin
        e_we    = 1'b1;
        e_waddr = t_addr;
        e_wdata = tn;
      end
      DP_S_WRITE: begin
        e_waddr = (cmd.row == ROW_TAIL) ? t_addr : h_addr;
        e_wdata = dv_res;
        r_wdata = dv_res;
        e_we    = cmd.row != ROW_REL;
        r_we    = cmd.row == ROW_REL;
      end
      default: ;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        it    <= in_item;
        idx   <= '0;
        acc   <= '0;
        tdist <= '0;
        upd   <= 1'b0;
        rd    <= '0;
      end
      DP_RD_DATA: begin
        if (it.operation == OPC_RD_ENT) rd <= (ent_ok_h && ei_ok) ? e_q : '0;
        else rd <= (rel_ok_h && ei_ok) ? r_q : '0;
      end
      DP_ADDR_T: begin
        hv <= e_q;
        rv <= r_q;
      end
      DP_D_DIFF:  xm  <= xd[17] ? 17'(-xd) : 17'(xd);
      DP_SQUARE:  sq  <= 34'(xm) * 34'(xm);
      DP_PASS:    sq  <= 34'(xm);
      DP_ACC: begin
        acc <= acc + ACC_W'(sq);
        idx <= idx + 1'b1;
      end
      DP_DIST: begin
        if (meas) tdist <= 31'(sq_root);
        else if (acc > ACC_W'(DIST_MAX)) tdist <= DIST_MAX;
        else tdist <= acc[30:0];
      end
      DP_MARG_MUL: prod <= 30'(pmargin) * 30'(it.threshold);
      DP_MARG_CMP: begin
        case (it.sample_kind)
          KIND_POS:  fire <= dd > 33'(base);
          KIND_NEAR: fire <= dd < (33'(base) <<< 1);
          KIND_FAR:  fire <= dd < $signed(33'(fmargin));
          default:   fire <= 1'b0;
        endcase
      end
      DP_UPD_BEGIN: begin
        idx <= '0;
        upd <= 1'b1;
      end
      DP_U_WRITE_HR: tn <= sat_el(tb + s_val);
      DP_U_WRITE_T:  idx <= idx + 1'b1;
      DP_N_BEGIN: begin
        idx <= '0;
        acc <= '0;
      end
      DP_N_MAG: xm <= sel_mag;
      DP_N_LATCH: begin
        nrm <= sq_root;
        idx <= '0;
      end
      DP_S_WRITE: idx <= idx + 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == DP_FINISH) begin
      rsp_valid           <= 1'b1;
      rsp_item.distance   <= tdist;
      rsp_item.updated    <= upd;
      rsp_item.read_value <= rd;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign status.operation = it.operation;
  assign status.train_ok  = ent_ok_h && ent_ok_t && rel_ok_r;
  assign status.dim_zero  = d_eff == '0;
  assign status.idx_last  = ((DIM_W+1)'(idx) + 1'b1) == (DIM_W+1)'(d_eff);
  assign status.use_l2    = meas;
  assign status.sqrt_busy = sq_busy;
  assign status.div_busy  = dv_busy;
  assign status.fire      = fire;
  assign status.big       = acc > ONE_SQ;
  assign status.out_free  = !rsp_valid || rsp_ready;
endmodule
`default_nettype wire

// File: sv/tee_ctrl.sv
// Controller state machine that sequences every item through the datapath.
`default_nettype none
module tee_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  output      tee_pkg::dp_cmd_t    cmd,
  input  wire tee_pkg::dp_status_t status
);
  import tee_pkg::*;

  ctrl_state_t state, state_next;
  row_sel_t    row, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= ROW_HEAD;
    end else begin
      state <= state_next;
      row   <= row_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    in_ready   = 1'b0;
    cmd.op     = DP_NOP;
    cmd.row    = row;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.operation inside {OPC_WR_ENT, OPC_WR_REL}) state_next = S_WRITE;
        else if (status.operation inside {OPC_RD_ENT, OPC_RD_REL}) state_next = S_RD_ADDR;
        else if (status.operation == OPC_TRAIN && status.train_ok)
          state_next = status.dim_zero ? S_D_SQRT : S_D_A;
        else state_next = S_FINISH;
      end
      S_WRITE: begin
        cmd.op     = DP_WRITE;
        state_next = S_FINISH;
      end
      S_RD_ADDR: begin
        cmd.op     = DP_RD_ADDR;
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.op     = DP_RD_DATA;
        state_next = S_FINISH;
      end
      S_D_A: begin
        cmd.op     = DP_ADDR_HR;
        state_next = S_D_B;
      end
      S_D_B: begin
        cmd.op     = DP_ADDR_T;
        state_next = S_D_C;
      end
      S_D_C: begin
        cmd.op     = DP_D_DIFF;
        state_next = S_D_D;
      end
      S_D_D: begin
        cmd.op     = status.use_l2 ? DP_SQUARE : DP_PASS;
        state_next = S_D_E;
      end
      S_D_E: begin
        cmd.op     = DP_ACC;
        state_next = status.idx_last ? S_D_SQRT : S_D_A;
      end
      S_D_SQRT: begin
        cmd.op     = DP_SQRT_START;
        state_next = S_D_WAIT;
      end
      S_D_WAIT: if (!status.sqrt_busy) state_next = S_DIST;
      S_DIST: begin
        cmd.op     = DP_DIST;
        state_next = S_MARG_MUL;
      end
      S_MARG_MUL: begin
        cmd.op     = DP_MARG_MUL;
        state_next = S_MARG_CMP;
      end
      S_MARG_CMP: begin
        cmd.op     = DP_MARG_CMP;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = status.fire ? S_UPD_BEGIN : S_FINISH;
      S_UPD_BEGIN: begin
        cmd.op     = DP_UPD_BEGIN;
        row_next   = ROW_HEAD;
        state_next = status.dim_zero ? S_FINISH : S_U_A;
      end
      S_U_A: begin
        cmd.op     = DP_ADDR_HR;
        state_next = S_U_B;
      end
      S_U_B: begin
        cmd.op     = DP_ADDR_T;
        state_next = S_U_C;
      end
      S_U_C: begin
        cmd.op     = DP_U_WRITE_HR;
        state_next = S_U_D;
      end
      S_U_D: begin
        cmd.op     = DP_U_WRITE_T;
        state_next = status.idx_last ? S_N_BEGIN : S_U_A;
      end
      S_N_BEGIN: begin
        cmd.op     = DP_N_BEGIN;
        state_next = S_N_A;
      end
      S_N_A: begin
        cmd.op     = DP_N_ADDR;
        state_next = S_N_B;
      end
      S_N_B: begin
        cmd.op     = DP_N_MAG;
        state_next = S_N_C;
      end
      S_N_C: begin
        cmd.op     = DP_SQUARE;
        state_next = S_N_D;
      end
      S_N_D: begin
        cmd.op     = DP_ACC;
        state_next = status.idx_last ? S_N_E : S_N_A;
      end
      S_N_E: begin
        if (status.big) begin
          cmd.op     = DP_SQRT_START;
          state_next = S_N_WAIT;
        end else begin
          state_next = S_NEXT_ROW;
        end
      end
      S_N_WAIT: if (!status.sqrt_busy) state_next = S_N_LATCH;
      S_N_LATCH: begin
        cmd.op     = DP_N_LATCH;
        state_next = S_S_A;
      end
      S_S_A: begin
        cmd.op     = DP_N_ADDR;
        state_next = S_S_B;
      end
      S_S_B: begin
        cmd.op     = DP_S_DIV;
        state_next = S_S_WAIT;
      end
      S_S_WAIT: if (!status.div_busy) state_next = S_S_C;
      S_S_C: begin
        cmd.op     = DP_S_WRITE;
        state_next = status.idx_last ? S_NEXT_ROW : S_S_A;
      end
      S_NEXT_ROW: begin
        case (row)
          ROW_HEAD: begin
            row_next   = ROW_TAIL;
            state_next = S_N_BEGIN;
          end
          ROW_TAIL: begin
            row_next   = ROW_REL;
            state_next = S_N_BEGIN;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.op     = DP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: sv/translation_embedding_update.sv
// Top level: translation embedding trainer with entity and relation tables.
// Writes and reads go straight to the tables; a train item first computes the distance,
// plus on an update steps every element, and per row computes the norm, plus when the norm
// exceeds one rescales each element with a bit-serial divide.
// One item at a time; the result register lets the next item in while a result waits.
// Reset clears the controller, configuration defaults and result register; tables stay.
`default_nettype none
module translation_embedding_update #(
  parameter int ENTITY_ROWS   = 1024,
  parameter int RELATION_ROWS = 64,
  parameter int MAX_DIMENSION = 128
) (
  input wire logic  clk,
  input wire logic  rst,
  tee_in_if.sink    req,
  tee_out_if.source rsp,
  tee_cfg_if.sink   cfg
);
  import tee_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  tee_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .cmd(cmd), .status(status)
  );

  tee_datapath #(
    .ENTITY_ROWS(ENTITY_ROWS), .RELATION_ROWS(RELATION_ROWS),
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_item(req.item),
    .cfg_valid(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.item)
  );
endmodule
`default_nettype wire

// File: sv/tee_checker.sv
// Port-level checks of the translation embedding update block and their binding.
`default_nettype none
module tee_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire tee_pkg::out_item_t rsp_item
);
  import tee_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item taken while busy");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.read_value != '0 |-> rsp_item.distance == '0 && !rsp_item.updated)
    else $error("read result mixed with train result");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result present after reset");
endmodule

bind translation_embedding_update tee_checker u_tee_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.item)
);
`default_nettype wire
